FILE: src/vp_pkg.sv
// ----------------------------------------------------------------------------
// vp_pkg: shared types and constants for the vector projection core
// Holds the sequencer state type and the fixed field widths of the datapath.
// ----------------------------------------------------------------------------
package vp_pkg;

   localparam int unsigned ElemWidth = 32;  // Q16.16 element width
   localparam int unsigned AccWidth  = 64;  // Q32.32 accumulator width
   localparam int unsigned StepWidth = 5;   // counts the 32 bit-serial steps
   localparam logic [StepWidth-1:0] LastStep = 5'd31;

   localparam logic [ElemWidth-1:0] Q16Max = 32'h7FFF_FFFF;
   localparam logic [ElemWidth-1:0] Q16Min = 32'h8000_0000;
   localparam logic [AccWidth-1:0]  AccMax = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [AccWidth-1:0]  AccMin = 64'h8000_0000_0000_0000;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_ACC,
      S_DIV_PREP,
      S_DIV_CHECK,
      S_DIV,
      S_DIV_ROUND,
      S_EMIT_RD,
      S_EMIT_LOAD,
      S_EMIT_MUL,
      S_EMIT_FIN,
      S_EMIT_WAIT
   } vp_state_type;

endpackage

FILE: src/vector_projection_core.sv
// ----------------------------------------------------------------------------
// vector_projection_core: projection of vector a onto vector b, Q16.16
// Each element pair: accept, 32 multiply steps, add. A new pair waits for
// the shared bit-serial multiplier. After the last pair the ratio follows
// (abs, range check, 32 divide steps, round; a zero |b|^2 or an out-of-range
// ratio skips the divide steps and the round); each result then takes a read,
// load, 32 multiply steps and finish before its transfer.
// Reset: synchronous, active high; clears sums, count, flags and sequencer.
// ----------------------------------------------------------------------------
module vector_projection_core
   import vp_pkg::*;
#(
   parameter int unsigned MAX_DIM = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] a_elem, [63:32] b_elem
   input  logic        req_tlast,   // last_in
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] proj_elem
   output logic        rsp_tlast,   // last_out
   output logic [1:0]  rsp_tuser    // [0] zero_divisor, [1] saturated
);

   localparam int unsigned CountWidth = $clog2(MAX_DIM + 1);
   localparam int unsigned AddrWidth  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   // sequencer
   vp_state_type state_ff, state_in;

   // vector state
   logic [CountWidth-1:0] count_ff, count_in;
   logic [AccWidth-1:0]   dot_ff, dot_in;
   logic [AccWidth-1:0]   mag_ff, mag_in;
   logic                  sat_seen_ff, sat_seen_in;
   logic                  last_pend_ff, last_pend_in;

   // bit-serial multiplier: high half accumulates, low half shifts out the
   // multiplier bits; two products run side by side during accumulation
   logic [AccWidth-1:0]   prod_ab_ff, prod_ab_in;
   logic [AccWidth-1:0]   prod_bb_ff, prod_bb_in;
   logic [ElemWidth-1:0]  mcand_ff, mcand_in;
   logic                  neg_ff, neg_in;
   logic [StepWidth-1:0]  step_ff, step_in;

   // restoring divider
   logic [AccWidth-1:0]   num_ff, num_in;
   logic [AccWidth-1:0]   rem_ff, rem_in;
   logic [ElemWidth-1:0]  num_lo_ff, num_lo_in;
   logic [ElemWidth-1:0]  quot_ff, quot_in;
   logic                  zero_ff, zero_in;
   logic [ElemWidth-1:0]  ratio_ff, ratio_in;
   logic                  rsat_ff, rsat_in;

   // emission
   logic [AddrWidth-1:0]  emit_idx_ff, emit_idx_in;
   logic [ElemWidth-1:0]  rd_data_ff;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ElemWidth-1:0]  proj_ff, proj_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_zero_ff, rsp_zero_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   // b element store
   logic [ElemWidth-1:0]  b_store [MAX_DIM];

   // combinational helpers
   logic                  req_xfer;
   logic                  rsp_xfer;
   logic                  has_room;
   logic [ElemWidth-1:0]  a_elem;
   logic [ElemWidth-1:0]  b_elem;
   logic [ElemWidth-1:0]  abs_a;
   logic [ElemWidth-1:0]  abs_b;
   logic [ElemWidth:0]    ab_sum;
   logic [ElemWidth:0]    bb_sum;
   logic [AccWidth-1:0]   ab_step;
   logic [AccWidth-1:0]   bb_step;
   logic [AccWidth:0]     dot_sum;
   logic [AccWidth:0]     mag_sum;
   logic [AccWidth+14:0]  div_lhs;
   logic [AccWidth+14:0]  div_rhs;
   logic [AccWidth-1:0]   rem_shift;
   logic                  rem_ge;
   logic                  round_up;
   logic [ElemWidth:0]    quot_round;
   logic [ElemWidth-1:0]  abs_rd;
   logic [ElemWidth-1:0]  abs_ratio;
   logic [AccWidth:0]     fin_sum;
   logic                  psat;
   logic                  emit_last;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_valid_ff && rsp_tready;
   assign has_room = (count_ff < CountWidth'(MAX_DIM));

   assign a_elem = req_tdata[31:0];
   assign b_elem = req_tdata[63:32];
   assign abs_a  = a_elem[ElemWidth-1] ? (~a_elem + 32'd1) : a_elem;
   assign abs_b  = b_elem[ElemWidth-1] ? (~b_elem + 32'd1) : b_elem;

   // one shift-add step: add the multiplicand when the multiplier LSB is set,
   // then shift the whole product register right by one
   assign ab_sum  = {1'b0, prod_ab_ff[63:32]} + (prod_ab_ff[0] ? {1'b0, mcand_ff} : 33'd0);
   assign bb_sum  = {1'b0, prod_bb_ff[63:32]} + (prod_bb_ff[0] ? {1'b0, mcand_ff} : 33'd0);
   assign ab_step = {ab_sum, prod_ab_ff[31:1]};
   assign bb_step = {bb_sum, prod_bb_ff[31:1]};

   // signed add of the product magnitude: invert plus carry-in for negatives
   assign dot_sum = {dot_ff[63], dot_ff} + ({1'b0, prod_ab_ff} ^ {(AccWidth+1){neg_ff}})
                    + {{AccWidth{1'b0}}, neg_ff};
   assign mag_sum = {mag_ff[63], mag_ff} + {1'b0, prod_bb_ff};

   // integer part of the ratio reaches 2^15 exactly when |dot| >= mag * 2^15
   assign div_lhs = {15'd0, num_ff};
   assign div_rhs = {mag_ff, 15'd0};

   assign rem_shift  = {rem_ff[62:0], num_lo_ff[ElemWidth-1]};
   assign rem_ge     = (rem_shift >= mag_ff);
   assign round_up   = ({rem_ff, 1'b0} >= {1'b0, mag_ff});
   assign quot_round = {1'b0, quot_ff} + {{ElemWidth{1'b0}}, round_up};

   assign abs_rd    = rd_data_ff[ElemWidth-1] ? (~rd_data_ff + 32'd1) : rd_data_ff;
   assign abs_ratio = ratio_ff[ElemWidth-1] ? (~ratio_ff + 32'd1) : ratio_ff;

   // signed product + 2^15; bits [47:16] are the floor-shifted result
   assign fin_sum = ({1'b0, prod_ab_ff} ^ {(AccWidth+1){neg_ff}}) + 65'd32768
                    + {{AccWidth{1'b0}}, neg_ff};
   // in range when the bits above the result all match its sign
   assign psat = !((&fin_sum[64:47]) || !(|fin_sum[64:47]));

   assign emit_last = ((CountWidth'(emit_idx_ff) + CountWidth'(1)) == count_ff);

   // -------------------------------------------------------------------------
   // next state
   // -------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (has_room) begin
                  state_in = S_MUL;
               end else if (req_tlast) begin
                  state_in = S_DIV_PREP;
               end
            end
         end
         S_MUL: begin
            if (step_ff == LastStep) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            state_in = last_pend_ff ? S_DIV_PREP : S_IDLE;
         end
         S_DIV_PREP: begin
            state_in = S_DIV_CHECK;
         end
         S_DIV_CHECK: begin
            priority if (zero_ff || (div_lhs >= div_rhs)) begin
               state_in = S_EMIT_RD;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (step_ff == LastStep) begin
               state_in = S_DIV_ROUND;
            end
         end
         S_DIV_ROUND: begin
            state_in = S_EMIT_RD;
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_LOAD;
         end
         S_EMIT_LOAD: begin
            state_in = S_EMIT_MUL;
         end
         S_EMIT_MUL: begin
            if (step_ff == LastStep) begin
               state_in = S_EMIT_FIN;
            end
         end
         S_EMIT_FIN: begin
            state_in = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (rsp_xfer) begin
               state_in = rsp_last_ff ? S_IDLE : S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // datapath next values
   // -------------------------------------------------------------------------
   always_comb begin
      count_in     = count_ff;
      dot_in       = dot_ff;
      mag_in       = mag_ff;
      sat_seen_in  = sat_seen_ff;
      last_pend_in = last_pend_ff;
      prod_ab_in   = prod_ab_ff;
      prod_bb_in   = prod_bb_ff;
      mcand_in     = mcand_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      num_lo_in    = num_lo_ff;
      quot_in      = quot_ff;
      zero_in      = zero_ff;
      ratio_in     = ratio_ff;
      rsat_in      = rsat_ff;
      emit_idx_in  = emit_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      proj_in      = proj_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_zero_in  = rsp_zero_ff;
      rsp_sat_in   = rsp_sat_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               last_pend_in = req_tlast;
               // drop pairs beyond the store depth, sums included
               if (has_room) begin
                  prod_ab_in = {32'd0, abs_a};
                  prod_bb_in = {32'd0, abs_b};
                  mcand_in   = abs_b;
                  neg_in     = a_elem[ElemWidth-1] ^ b_elem[ElemWidth-1];
                  step_in    = '0;
                  count_in   = count_ff + CountWidth'(1);
               end
            end
         end
         S_MUL: begin
            prod_ab_in = ab_step;
            prod_bb_in = bb_step;
            step_in    = step_ff + StepWidth'(1);
         end
         S_ACC: begin
            // saturate each sum on signed overflow
            if (dot_sum[64] != dot_sum[63]) begin
               dot_in      = dot_sum[64] ? AccMin : AccMax;
               sat_seen_in = 1'b1;
            end else begin
               dot_in = dot_sum[63:0];
            end
            if (mag_sum[64] != mag_sum[63]) begin
               mag_in      = mag_sum[64] ? AccMin : AccMax;
               sat_seen_in = 1'b1;
            end else begin
               mag_in = mag_sum[63:0];
            end
         end
         S_DIV_PREP: begin
            num_in  = dot_ff[63] ? (~dot_ff + 64'd1) : dot_ff;
            neg_in  = dot_ff[63];
            zero_in = (mag_ff == '0);
         end
         S_DIV_CHECK: begin
            emit_idx_in = '0;
            rsat_in     = 1'b0;
            priority if (zero_ff) begin
               ratio_in = '0;
            end else if (div_lhs >= div_rhs) begin
               ratio_in = neg_ff ? Q16Min : Q16Max;
               rsat_in  = 1'b1;
            end else begin
               // integer part is below 2^15, so the upper remainder starts below mag
               rem_in    = {16'd0, num_ff[63:16]};
               num_lo_in = {num_ff[15:0], 16'd0};
               step_in   = '0;
            end
         end
         S_DIV: begin
            rem_in    = rem_ge ? (rem_shift - mag_ff) : rem_shift;
            quot_in   = {quot_ff[ElemWidth-2:0], rem_ge};
            num_lo_in = {num_lo_ff[ElemWidth-2:0], 1'b0};
            step_in   = step_ff + StepWidth'(1);
         end
         S_DIV_ROUND: begin
            // round half away from zero; only a positive ratio can overflow,
            // and rounding up can carry it to exactly 2^31
            if (neg_ff) begin
               ratio_in = ~quot_round[ElemWidth-1:0] + 32'd1;
            end else if (quot_round[ElemWidth] || quot_round[ElemWidth-1]) begin
               ratio_in = Q16Max;
               rsat_in  = 1'b1;
            end else begin
               ratio_in = quot_round[ElemWidth-1:0];
            end
         end
         S_EMIT_RD: begin
            // store read is registered in the memory block
         end
         S_EMIT_LOAD: begin
            prod_ab_in = {32'd0, abs_rd};
            mcand_in   = abs_ratio;
            neg_in     = rd_data_ff[ElemWidth-1] ^ ratio_ff[ElemWidth-1];
            step_in    = '0;
         end
         S_EMIT_MUL: begin
            prod_ab_in = ab_step;
            step_in    = step_ff + StepWidth'(1);
         end
         S_EMIT_FIN: begin
            proj_in      = psat ? (fin_sum[64] ? Q16Min : Q16Max) : fin_sum[47:16];
            rsp_last_in  = emit_last;
            rsp_zero_in  = zero_ff;
            rsp_sat_in   = sat_seen_ff || rsat_ff || psat;
            rsp_valid_in = 1'b1;
         end
         S_EMIT_WAIT: begin
            if (rsp_xfer) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  // vector done: clear sums, count and flags
                  dot_in      = '0;
                  mag_in      = '0;
                  count_in    = '0;
                  sat_seen_in = 1'b0;
               end else begin
                  emit_idx_in = emit_idx_ff + AddrWidth'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dot_ff       <= '0;
         mag_ff       <= '0;
         sat_seen_ff  <= 1'b0;
         last_pend_ff <= 1'b0;
         step_ff      <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dot_ff       <= dot_in;
         mag_ff       <= mag_in;
         sat_seen_ff  <= sat_seen_in;
         last_pend_ff <= last_pend_in;
         step_ff      <= step_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ab_ff  <= prod_ab_in;
      prod_bb_ff  <= prod_bb_in;
      mcand_ff    <= mcand_in;
      neg_ff      <= neg_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      num_lo_ff   <= num_lo_in;
      quot_ff     <= quot_in;
      zero_ff     <= zero_in;
      ratio_ff    <= ratio_in;
      rsat_ff     <= rsat_in;
      proj_ff     <= proj_in;
      rsp_last_ff <= rsp_last_in;
      rsp_zero_ff <= rsp_zero_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   // b element store: write on an accepted pair, registered read during emission
   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && req_xfer && has_room) begin
         b_store[count_ff[AddrWidth-1:0]] <= b_elem;
      end
      if (state_ff == S_EMIT_RD) begin
         rd_data_ff <= b_store[emit_idx_ff];
      end
   end

   // -------------------------------------------------------------------------
   // outputs
   // -------------------------------------------------------------------------
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = proj_ff;
      rsp_tlast  = rsp_last_ff;
      rsp_tuser  = {rsp_sat_ff, rsp_zero_ff};
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vector_projection_core
// Streams element pairs into the core and predicts every projected element
// with a bit-exact model of the sums, the rounded ratio and the saturating
// products. A scoreboard compares each result transfer against the oldest
// prediction. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
   import vp_pkg::*;

   localparam int MaxDim        = 16;
   localparam int HoldCycles    = 400;   // long receiver hold-off
   localparam int WatchdogLimit = 5000;  // cycles with no transfer at all
   localparam int DrainCycles   = 200;
   localparam int ReportLimit   = 10;

   typedef struct {
      int proj;
      bit last;
      bit zero_div;
      bit sat;
   } proj_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [31:0] a_elem, [63:32] b_elem
   logic        req_tlast = 1'b0; // last_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] proj_elem
   logic        rsp_tlast;        // last_out
   logic [1:0]  rsp_tuser;        // [0] zero_divisor, [1] saturated

   // shadow of the core's vector state
   int      b_elems [MaxDim];
   longint  dot_sum;
   longint  mag_sum;
   int      elem_cnt;
   bit      sum_sat;

   proj_result_type proj_expect_q[$];
   int      error_count   = 0;
   int      pairs_sent    = 0;
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;
   logic    hold_request  = 1'b0;
   int      idle_cycles   = 0;

   vector_projection_core #(
      .MAX_DIM(MaxDim)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Arithmetic of the prediction
   // ------------------------------------------------------------------------

   // Clamp to the signed 32-bit range and flag any clipping.
   function automatic int clip32(input longint v, inout bit sat);
      if (v > longint'(32'sh7FFF_FFFF)) begin
         sat = 1'b1;
         return Q16Max;
      end
      if (v < -longint'(64'sh8000_0000)) begin
         sat = 1'b1;
         return Q16Min;
      end
      return int'(v);
   endfunction

   // Signed 64-bit add that sticks at the rails instead of wrapping.
   function automatic longint add_clip64(input longint x, input longint y, inout bit sat);
      logic [64:0] s;
      s = {x[63], x} + {y[63], y};
      if (s[64] != s[63]) begin
         sat = 1'b1;
         return s[64] ? AccMin : AccMax;
      end
      return s[63:0];
   endfunction

   // Q32.32 / Q32.32 -> Q16.16, round half away from zero; den is positive.
   function automatic int divide_ratio(input longint num, input longint den, inout bit sat);
      bit          neg;
      bit [63:0]   n, d, q, r;
      longint      signed_q;
      neg = (num < 0);
      n   = neg ? -num : num;   // most negative sum maps to 2^63 unsigned
      d   = den;
      q   = n / d;
      r   = n % d;
      if (q >= 64'h8000) begin
         sat = 1'b1;
         return neg ? Q16Min : Q16Max;
      end
      for (int k = 0; k < 16; k++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r    = r - d;
            q[0] = 1'b1;
         end
      end
      if (r >= d - r)
         q = q + 1;
      signed_q = longint'(q);
      return clip32(neg ? -signed_q : signed_q, sat);
   endfunction

   // Fold one accepted pair into the shadow state; on the last pair queue
   // one projected element per stored b element, then clear the vector.
   function automatic void predict_pair(input int a_val, input int b_val, input bit last_val);
      bit              zero_div;
      bit              ratio_sat;
      bit              prod_sat;
      int              ratio;
      longint          prod;
      proj_result_type res;
      if (elem_cnt < MaxDim) begin
         b_elems[elem_cnt] = b_val;
         elem_cnt++;
         dot_sum = add_clip64(dot_sum, longint'(a_val) * longint'(b_val), sum_sat);
         mag_sum = add_clip64(mag_sum, longint'(b_val) * longint'(b_val), sum_sat);
      end
      if (!last_val)
         return;
      zero_div  = (mag_sum == 0);
      ratio_sat = 1'b0;
      ratio     = 0;
      if (!zero_div)
         ratio = divide_ratio(dot_sum, mag_sum, ratio_sat);
      for (int i = 0; i < elem_cnt; i++) begin
         prod_sat = 1'b0;
         res.proj = 0;
         if (!zero_div) begin
            // round half up: add half an LSB, then floor
            prod     = longint'(b_elems[i]) * longint'(ratio) + 64'sd32768;
            res.proj = clip32(prod >>> 16, prod_sat);
         end
         res.last     = (i == elem_cnt - 1);
         res.zero_div = zero_div;
         res.sat      = sum_sat | ratio_sat | prod_sat;
         proj_expect_q.push_back(res);
      end
      dot_sum  = 0;
      mag_sum  = 0;
      elem_cnt = 0;
      sum_sat  = 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   // Offer one pair, optionally after a random gap, and hold it until the
   // core takes it. Valid stays high into the next call unless it idles.
   task automatic send_pair(input int a_val, input int b_val, input bit last_val);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b_val, a_val};
      req_tlast  <= last_val;
      do @(posedge clock); while (!req_tready);
      predict_pair(a_val, b_val, last_val);
      pairs_sent++;
   endtask

   // Mix of rails, zero, small magnitudes and fully random words.
   function automatic int random_elem();
      case ($urandom_range(9))
         0:       return Q16Max;
         1:       return Q16Min;
         2:       return 0;
         3, 4:    return int'($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000;
         5:       return int'($urandom_range(32'h0000_0FFF)) - 32'sh0000_0800;
         default: return $urandom;
      endcase
   endfunction

   // One vector of random content; now and then longer than the store,
   // and now and then with an all-zero b.
   task automatic send_random_vector();
      int len;
      int sel;
      bit zero_b;
      sel = $urandom_range(99);
      if (sel < 70)
         len = $urandom_range(1, 4);
      else if (sel < 92)
         len = $urandom_range(5, MaxDim);
      else
         len = $urandom_range(MaxDim + 1, MaxDim + 4);
      zero_b = ($urandom_range(9) == 0);
      for (int i = 0; i < len; i++)
         send_pair(random_elem(), zero_b ? 0 : random_elem(), i == len - 1);
   endtask

   task automatic test_extremes();
      send_pair(Q16Max, Q16Max, 1'b1);
      send_pair(Q16Min, Q16Max, 1'b1);
      send_pair(0, Q16Min, 1'b1);
   endtask

   task automatic test_zero_divisor();
      send_pair(Q16Max, 0, 1'b0);
      send_pair(Q16Min, 0, 1'b1);
   endtask

   // tiny b against a full-scale a drives the ratio past both rails
   task automatic test_ratio_saturation();
      send_pair(Q16Max, 1, 1'b1);
      send_pair(Q16Min, 1, 1'b1);
   endtask

   // ratio near 16792 times b = 2.0 clips; times b = 1.9 does not
   task automatic test_product_saturation();
      send_pair(32'h7FFF_0000, 32'h0002_0000, 1'b0);
      send_pair(32'h7FFF_0000, 32'h0001_E666, 1'b1);
   endtask

   // drive dot into both rails and |b|^2 into its upper rail, including the most negative sum
   task automatic test_sum_saturation();
      for (int i = 0; i < 4; i++)
         send_pair(Q16Min, Q16Min, i == 3);
      for (int i = 0; i < 3; i++)
         send_pair(Q16Max, Q16Min, i == 2);
   endtask

   // ratio of exactly half an LSB, positive and negative
   task automatic test_rounding_ties();
      send_pair(1, 32'h0002_0000, 1'b1);
      send_pair(-1, 32'h0002_0000, 1'b1);
   endtask

   task automatic test_traffic(input int idle_pct, input int stall_pct, input int n_pairs);
      int start;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start = pairs_sent;
      while (pairs_sent - start < n_pairs)
         send_random_vector();
   endtask

   // Hold the receiver off right after a vector closes and keep offering
   // the next one, so the core backs up and stalls its input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      for (int i = 0; i < 3; i++)
         send_pair(random_elem(), random_elem(), i == 2);
      hold_request = 1'b1;
      for (int i = 0; i < 6; i++)
         send_pair(random_elem(), random_elem(), i == 5);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random stalls, plus the long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_request = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Scoreboard: compare each result transfer with the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      proj_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (proj_expect_q.size() == 0) begin
            error_count++;
            if (error_count <= ReportLimit)
               $display("unexpected result: proj=%h last=%b user=%b",
                        rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            exp_res = proj_expect_q.pop_front();
            if (rsp_tdata !== exp_res.proj || rsp_tlast !== exp_res.last ||
                rsp_tuser[0] !== exp_res.zero_div || rsp_tuser[1] !== exp_res.sat) begin
               error_count++;
               if (error_count <= ReportLimit)
                  $display("mismatch (exp/got): proj %h/%h last %b/%b zdiv %b/%b sat %b/%b",
                           exp_res.proj, rsp_tdata, exp_res.last, rsp_tlast,
                           exp_res.zero_div, rsp_tuser[0], exp_res.sat, rsp_tuser[1]);
            end
         end
      end
   end

   // Watchdog: end the run if no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence of tests
   // ------------------------------------------------------------------------
   initial begin
      dot_sum  = 0;
      mag_sum  = 0;
      elem_cnt = 0;
      sum_sat  = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_zero_divisor();
      test_ratio_saturation();
      test_product_saturation();
      test_sum_saturation();
      test_rounding_ties();
      test_traffic(0, 0, 40);
      test_traffic(83, 0, 40);
      test_traffic(0, 83, 40);
      test_traffic(8, 8, 40);
      test_backpressure();

      req_tvalid <= 1'b0;
      wait (proj_expect_q.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: sim.f
src/vp_pkg.sv
src/vector_projection_core.sv
tb/testbench.sv
